### rtl/uer_pkg.sv
package uer_pkg;

    // counter width default and fixed field widths
    localparam int COUNT_BITS_DEF = 24;
    localparam int LEN_W          = 16;
    localparam int TIMEOUT_W      = 24;
    localparam int SPEED_W        = 10;
    localparam int DIST_W         = 33;
    localparam int STATUS_W       = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 2'd3;

    // register reset values
    localparam logic [LEN_W-1:0]     TRIG_LOW_RST  = 16'd10;
    localparam logic [LEN_W-1:0]     TRIG_HIGH_RST = 16'd20;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 24'd500000;
    localparam logic [SPEED_W-1:0]   SPEED_RST     = 10'd343;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RISE_TO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FALL_TO = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]     trig_low;
        logic [LEN_W-1:0]     trig_high;
        logic [TIMEOUT_W-1:0] timeout;
        logic [SPEED_W-1:0]   speed;
    } uer_cfg_t;

    typedef struct packed {
        logic                trigger;
        logic                busy;
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [DIST_W-1:0]   distance;
    } uer_result_t;

endpackage

### rtl/ultrasonic_echo_ranger_core.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_ready  | start_req, echo (one microsecond tick)
// output   | out_valid / out_ready| trigger, busy_res, done_res, status,
//          |                      | distance
// config   | cfg_we               | cfg_index, cfg_data
//
// one tick word accepted per cycle while the output is not stalled; its result
// appears in the output register on the following cycle
// the phase counter and the 34-bit distance multiply sit combinationally between
// the state registers and the result register
// rst_n clears phase, counter, last status and distance and reloads registers
// input is taken whenever the result register is empty or being read, so a
// stall on the output holds the input for just as long

module ultrasonic_echo_ranger_core
#(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              start_req,
    input  logic                              echo,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              trigger,
    output logic                              busy_res,
    output logic                              done_res,
    output logic [uer_pkg::STATUS_W-1:0]      status,
    output logic [uer_pkg::DIST_W-1:0]        distance,
    input  logic                              cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data
);

    uer_pkg::uer_cfg_t    cfg;
    uer_pkg::uer_result_t res;
    uer_pkg::uer_result_t result;
    logic                 accept;

    // configuration registers
    uer_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // measurement sequencer
    uer_fsm #(.COUNT_BITS(COUNT_BITS)) u_fsm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .start_req (start_req),
        .echo      (echo),
        .cfg       (cfg),
        .res       (res)
    );

    // result register
    uer_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .accept    (accept),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign trigger  = result.trigger;
    assign busy_res = result.busy;
    assign done_res = result.done;
    assign status   = result.status;
    assign distance = result.distance;

endmodule

### rtl/uer_cfg.sv
module uer_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data,
    output uer_pkg::uer_cfg_t                 cfg
);

    uer_pkg::uer_cfg_t cfg_reg;

    // register file, writes only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trig_low  <= uer_pkg::TRIG_LOW_RST;
            cfg_reg.trig_high <= uer_pkg::TRIG_HIGH_RST;
            cfg_reg.timeout   <= uer_pkg::TIMEOUT_RST;
            cfg_reg.speed     <= uer_pkg::SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uer_pkg::REG_TRIG_LOW:  cfg_reg.trig_low  <= cfg_data[uer_pkg::LEN_W-1:0];
                uer_pkg::REG_TRIG_HIGH: cfg_reg.trig_high <= cfg_data[uer_pkg::LEN_W-1:0];
                uer_pkg::REG_TIMEOUT:   cfg_reg.timeout   <= cfg_data[uer_pkg::TIMEOUT_W-1:0];
                uer_pkg::REG_SPEED:     cfg_reg.speed     <= cfg_data[uer_pkg::SPEED_W-1:0];
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/uer_fsm.sv
module uer_fsm
#(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  start_req,
    input  logic                  echo,
    input  uer_pkg::uer_cfg_t     cfg,
    output uer_pkg::uer_result_t  res
);

    localparam int CMP_W  = (COUNT_BITS > uer_pkg::TIMEOUT_W) ? COUNT_BITS : uer_pkg::TIMEOUT_W;
    localparam int PROD_W = COUNT_BITS + uer_pkg::SPEED_W;
    localparam int HALF_W = PROD_W - 1;
    localparam int EXT_W  = (HALF_W > uer_pkg::DIST_W) ? HALF_W : uer_pkg::DIST_W + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0]
    {
        PH_IDLE  = 3'd0,
        PH_TLOW  = 3'd1,
        PH_THIGH = 3'd2,
        PH_RISE  = 3'd3,
        PH_FALL  = 3'd4
    } phase_t;

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic [COUNT_BITS-1:0]           count_reg;
    logic [COUNT_BITS-1:0]           count_next;
    logic [uer_pkg::DIST_W-1:0]      dist_reg;
    logic [uer_pkg::DIST_W-1:0]      dist_next;
    logic [uer_pkg::STATUS_W-1:0]    status_reg;
    logic [uer_pkg::STATUS_W-1:0]    status_next;

    logic [COUNT_BITS-1:0]           count_bump;
    logic                            bump_expired;
    logic [PROD_W-1:0]               product;
    logic [EXT_W-1:0]                half_ext;
    logic [uer_pkg::DIST_W-1:0]      dist_sat;
    logic                            trig;
    logic                            done;

    // saturating tick counter and timeout check
    assign count_bump   = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
    assign bump_expired = (CMP_W'(count_bump) >= CMP_W'(cfg.timeout)) || (count_bump == CNT_MAX);

    // echo width times speed, halved and clipped to the distance field
    assign product  = PROD_W'(count_reg) * PROD_W'(cfg.speed);
    assign half_ext = EXT_W'(product[PROD_W-1:1]);
    assign dist_sat = (|half_ext[EXT_W-1:uer_pkg::DIST_W]) ? {uer_pkg::DIST_W{1'b1}}
                                                           : half_ext[uer_pkg::DIST_W-1:0];

    // next state for one tick
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        dist_next   = dist_reg;
        status_next = status_reg;
        trig        = 1'b0;
        done        = 1'b0;
        case (phase_reg)
            PH_TLOW:
            begin
                count_next = count_bump;
                if (count_bump >= COUNT_BITS'(cfg.trig_low))
                begin
                    phase_next = PH_THIGH;
                    count_next = '0;
                end
            end
            PH_THIGH:
            begin
                trig       = 1'b1;
                count_next = count_bump;
                if (count_bump >= COUNT_BITS'(cfg.trig_high))
                begin
                    phase_next = PH_RISE;
                    count_next = '0;
                end
            end
            PH_RISE:
            begin
                if (echo)
                begin
                    phase_next = PH_FALL;
                    count_next = COUNT_BITS'(1);
                end
                else
                begin
                    count_next = count_bump;
                    if (bump_expired)
                    begin
                        phase_next  = PH_IDLE;
                        count_next  = '0;
                        status_next = uer_pkg::STATUS_RISE_TO;
                        dist_next   = '0;
                        done        = 1'b1;
                    end
                end
            end
            PH_FALL:
            begin
                if (!echo)
                begin
                    phase_next  = PH_IDLE;
                    count_next  = '0;
                    status_next = uer_pkg::STATUS_OK;
                    dist_next   = dist_sat;
                    done        = 1'b1;
                end
                else
                begin
                    count_next = count_bump;
                    if (bump_expired)
                    begin
                        phase_next  = PH_IDLE;
                        count_next  = '0;
                        status_next = uer_pkg::STATUS_FALL_TO;
                        dist_next   = '0;
                        done        = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (start_req)
                begin
                    phase_next = PH_TLOW;
                    count_next = '0;
                end
            end
        endcase
    end

    // state advances once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            dist_reg   <= '0;
            status_reg <= uer_pkg::STATUS_OK;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            dist_reg   <= dist_next;
            status_reg <= status_next;
        end
    end

    // result of this tick
    assign res.trigger  = trig;
    assign res.busy     = (phase_next != PH_IDLE);
    assign res.done     = done;
    assign res.status   = status_next;
    assign res.distance = dist_next;

`ifndef SYNTH
    // counter is clear whenever no measurement runs
    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (count_reg == '0))
        else $error("tick counter not clear in idle");

    // echo fall ends the measurement with a good status
    a_fall_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PH_FALL) && !echo)
        |=> ((phase_reg == PH_IDLE) && (status_reg == uer_pkg::STATUS_OK)))
        else $error("echo fall did not finish measurement");

    // a finished measurement leaves the block idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.done) |=> (phase_reg == PH_IDLE))
        else $error("still busy after done");
`endif

endmodule

### rtl/uer_out.sv
module uer_out
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  accept,
    input  uer_pkg::uer_result_t  res,
    output logic                  out_valid,
    input  logic                  out_ready,
    output uer_pkg::uer_result_t  result
);

    logic                 out_valid_reg;
    uer_pkg::uer_result_t result_reg;

    // take a new word whenever the result register is empty or empties this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`ifndef SYNTH
    // a failed measurement never reports a distance
    a_fail_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.status != uer_pkg::STATUS_OK))
        |-> (result_reg.distance == '0))
        else $error("distance set with error status");

    // done always comes with busy low
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.done) |-> !result_reg.busy)
        else $error("done reported while busy");

    // trigger pulse only inside a measurement
    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.trigger) |-> result_reg.busy)
        else $error("trigger high outside measurement");
`endif

endmodule
